FILE: rtl/core/hybrid_position_force_pid_assert.svh
// ----------------------------------------------------------------------------
// hybrid_position_force_pid assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef HYBRID_POSITION_FORCE_PID_ASSERT_SVH
`define HYBRID_POSITION_FORCE_PID_ASSERT_SVH

// same-cycle implication
`define HPF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hpfpid_pkg.sv
// ----------------------------------------------------------------------------
// hpfpid_pkg
// types, constants and helper functions of the hybrid position/force pid
// ----------------------------------------------------------------------------
package hpfpid_pkg;

    // axis count and sizes
    localparam int AXES       = 3;
    localparam int INTEG_BITS = 48;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DIFF_W     = DATA_W + 2;
    localparam int ILO_W      = INTEG_BITS / 2;
    localparam int IHI_W      = INTEG_BITS - ILO_W;
    localparam int PKP_W      = GAIN_W + 1 + ERR_W;
    localparam int PKD_W      = GAIN_W + 1 + DIFF_W;
    localparam int PLO_W      = GAIN_W + 1 + ILO_W + 1;
    localparam int PHI_W      = GAIN_W + 1 + IHI_W;
    localparam int PID_W      = GAIN_W + INTEG_BITS + 2;
    localparam int ACC_W      = PID_W + 2;
    localparam int CFG_IDX_W  = 8;

    // force clamp at plus or minus 50.0 in q16.16
    localparam logic signed [DATA_W-1:0] FRC_LIMIT = 32'sd3276800;

    // gain reset values, q8.24
    localparam logic [GAIN_W-1:0] POS_KP_RST = 32'd3019899;
    localparam logic [GAIN_W-1:0] POS_KI_RST = 32'd0;
    localparam logic [GAIN_W-1:0] POS_KD_RST = 32'd50332;
    localparam logic [GAIN_W-1:0] FRC_KP_RST = 32'd3355;
    localparam logic [GAIN_W-1:0] FRC_KI_RST = 32'd0;
    localparam logic [GAIN_W-1:0] FRC_KD_RST = 32'd805;

    typedef logic signed [DATA_W-1:0]     q16_t;
    typedef logic        [GAIN_W-1:0]     gain_t;
    typedef logic signed [ERR_W-1:0]      err_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [INTEG_BITS-1:0] integ_t;
    typedef logic signed [PKP_W-1:0]      prod_kp_t;
    typedef logic signed [PKD_W-1:0]      prod_kd_t;
    typedef logic signed [PLO_W-1:0]      prod_lo_t;
    typedef logic signed [PHI_W-1:0]      prod_hi_t;
    typedef logic signed [PID_W-1:0]      pid_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_KP     = 8'd0,
        REG_POS_KI     = 8'd1,
        REG_POS_KD     = 8'd2,
        REG_FRC_KP     = 8'd3,
        REG_FRC_KI     = 8'd4,
        REG_FRC_KD     = 8'd5,
        REG_POS_ENABLE = 8'd6,
        REG_FRC_ENABLE = 8'd7
    } cfg_reg_t;

    // clamp raw force to the sensor limit
    function automatic q16_t clamp_force(input q16_t f);
        q16_t r;
        if (f >= FRC_LIMIT)
        begin
            r = FRC_LIMIT;
        end
        else if (f <= -FRC_LIMIT)
        begin
            r = -FRC_LIMIT;
        end
        else
        begin
            r = f;
        end
        return r;
    endfunction

    // integrator add with saturation at the signed limits
    function automatic integ_t integ_sat(input integ_t i, input diff_t d);
        logic signed [INTEG_BITS:0] s;
        integ_t                     r;
        s = $signed({i[INTEG_BITS-1], i})
            + $signed({{(INTEG_BITS + 1 - DIFF_W){d[DIFF_W-1]}}, d});
        if (s[INTEG_BITS] != s[INTEG_BITS-1])
        begin
            r = s[INTEG_BITS] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                              : {1'b0, {(INTEG_BITS-1){1'b1}}};
        end
        else
        begin
            r = s[INTEG_BITS-1:0];
        end
        return r;
    endfunction

    // floor of acc / 2^FRAC_W, saturated to a q16.16 word
    function automatic q16_t shift_sat(input acc_t acc);
        logic [ACC_W-FRAC_W-DATA_W:0] hi;
        q16_t                         r;
        hi = acc[ACC_W-1:FRAC_W+DATA_W-1];
        if ((hi == '0) || (hi == '1))
        begin
            r = acc[FRAC_W+DATA_W-1:FRAC_W];
        end
        else
        begin
            r = acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                             : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/hybrid_position_force_pid.sv
// ----------------------------------------------------------------------------
// hybrid_position_force_pid: three-axis hybrid position/force pid controller
// throughput 1 request/cycle while cmd_stall does not back up the full pipeline
// five register stages: input, error/integrator update, products, pid sums, output
// reset clears pipeline valids, error and integrator state, and loads default gains
// ----------------------------------------------------------------------------
`include "hybrid_position_force_pid_assert.svh"

module hybrid_position_force_pid
    import hpfpid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    // request channel
    input  logic                 tick_valid,
    output logic                 tick_stall,
    input  logic signed [31:0]   cur_pos_x,
    input  logic signed [31:0]   cur_pos_y,
    input  logic signed [31:0]   cur_pos_z,
    input  logic signed [31:0]   force_raw_x,
    input  logic signed [31:0]   force_raw_y,
    input  logic signed [31:0]   force_raw_z,
    input  logic signed [31:0]   target_pos_x,
    input  logic signed [31:0]   target_pos_y,
    input  logic signed [31:0]   target_pos_z,
    input  logic signed [31:0]   target_frc_x,
    input  logic signed [31:0]   target_frc_y,
    input  logic signed [31:0]   target_frc_z,

    // result channel
    output logic                 cmd_valid,
    input  logic                 cmd_stall,
    output logic signed [31:0]   cmd_pos_x,
    output logic signed [31:0]   cmd_pos_y,
    output logic signed [31:0]   cmd_pos_z
);

    // configuration registers
    gain_t pos_kp_reg, pos_ki_reg, pos_kd_reg;
    gain_t frc_kp_reg, frc_ki_reg, frc_kd_reg;
    logic  pos_en_reg, frc_en_reg;

    // request fields per axis
    q16_t in_cur  [AXES];
    q16_t in_frc  [AXES];
    q16_t in_tpos [AXES];
    q16_t in_tfrc [AXES];

    // stage a: input register
    logic a_valid_reg;
    q16_t a_cur_reg  [AXES];
    q16_t a_frc_reg  [AXES];
    q16_t a_tpos_reg [AXES];
    q16_t a_tfrc_reg [AXES];

    // stage b: controller state doubles as the error and integrator stage
    logic   b_valid_reg;
    q16_t   b_cur_reg      [AXES];
    err_t   pos_prev_reg   [AXES];
    integ_t pos_integ_reg  [AXES];
    diff_t  b_pos_diff_reg [AXES];
    err_t   frc_prev_reg   [AXES];
    integ_t frc_integ_reg  [AXES];
    diff_t  b_frc_diff_reg [AXES];
    err_t   pos_prev_next  [AXES];
    integ_t pos_integ_next [AXES];
    diff_t  pos_diff_next  [AXES];
    err_t   frc_prev_next  [AXES];
    integ_t frc_integ_next [AXES];
    diff_t  frc_diff_next  [AXES];

    // stage c: gain products
    logic     c_valid_reg;
    q16_t     c_cur_reg    [AXES];
    prod_kp_t c_pos_kp_reg [AXES];
    prod_kd_t c_pos_kd_reg [AXES];
    prod_lo_t c_pos_lo_reg [AXES];
    prod_hi_t c_pos_hi_reg [AXES];
    prod_kp_t c_frc_kp_reg [AXES];
    prod_kd_t c_frc_kd_reg [AXES];
    prod_lo_t c_frc_lo_reg [AXES];
    prod_hi_t c_frc_hi_reg [AXES];
    prod_kp_t c_pos_kp_next [AXES];
    prod_kd_t c_pos_kd_next [AXES];
    prod_lo_t c_pos_lo_next [AXES];
    prod_hi_t c_pos_hi_next [AXES];
    prod_kp_t c_frc_kp_next [AXES];
    prod_kd_t c_frc_kd_next [AXES];
    prod_lo_t c_frc_lo_next [AXES];
    prod_hi_t c_frc_hi_next [AXES];

    // stage d: pid sums
    logic d_valid_reg;
    q16_t d_cur_reg     [AXES];
    pid_t d_pos_pid_reg [AXES];
    pid_t d_frc_pid_reg [AXES];
    pid_t d_pos_pid_next [AXES];
    pid_t d_frc_pid_next [AXES];

    // stage e: output register
    logic cmd_valid_reg;
    q16_t cmd_reg  [AXES];
    q16_t cmd_next [AXES];

    // stage advance chain
    logic adv_a, adv_b, adv_c, adv_d, adv_e;
    logic state_upd;

    assign adv_e     = !cmd_valid_reg || !cmd_stall;
    assign adv_d     = !d_valid_reg || adv_e;
    assign adv_c     = !c_valid_reg || adv_d;
    assign adv_b     = !b_valid_reg || adv_c;
    assign adv_a     = !a_valid_reg || adv_b;
    assign state_upd = adv_b && a_valid_reg;

    assign tick_stall = !adv_a;
    assign cfg_ready  = 1'b1;
    assign cmd_valid  = cmd_valid_reg;
    assign cmd_pos_x  = cmd_reg[0];
    assign cmd_pos_y  = cmd_reg[1];
    assign cmd_pos_z  = cmd_reg[2];

    // field gather
    assign in_cur[0]  = cur_pos_x;
    assign in_cur[1]  = cur_pos_y;
    assign in_cur[2]  = cur_pos_z;
    assign in_frc[0]  = force_raw_x;
    assign in_frc[1]  = force_raw_y;
    assign in_frc[2]  = force_raw_z;
    assign in_tpos[0] = target_pos_x;
    assign in_tpos[1] = target_pos_y;
    assign in_tpos[2] = target_pos_z;
    assign in_tfrc[0] = target_frc_x;
    assign in_tfrc[1] = target_frc_y;
    assign in_tfrc[2] = target_frc_z;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_kp_reg <= POS_KP_RST;
            pos_ki_reg <= POS_KI_RST;
            pos_kd_reg <= POS_KD_RST;
            frc_kp_reg <= FRC_KP_RST;
            frc_ki_reg <= FRC_KI_RST;
            frc_kd_reg <= FRC_KD_RST;
            pos_en_reg <= 1'b1;
            frc_en_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POS_KP:     pos_kp_reg <= cfg_data;
                REG_POS_KI:     pos_ki_reg <= cfg_data;
                REG_POS_KD:     pos_kd_reg <= cfg_data;
                REG_FRC_KP:     frc_kp_reg <= cfg_data;
                REG_FRC_KI:     frc_ki_reg <= cfg_data;
                REG_FRC_KD:     frc_kd_reg <= cfg_data;
                REG_POS_ENABLE: pos_en_reg <= cfg_data[0];
                REG_FRC_ENABLE: frc_en_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= tick_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (adv_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (adv_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (adv_e)
            begin
                cmd_valid_reg <= d_valid_reg;
            end
        end
    end

    // stage a payload
    always_ff @(posedge clk)
    begin
        if (adv_a && tick_valid)
        begin
            a_cur_reg  <= in_cur;
            a_frc_reg  <= in_frc;
            a_tpos_reg <= in_tpos;
            a_tfrc_reg <= in_tfrc;
        end
    end

    // errors, error differences and integrator update
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            pos_prev_next[a]  = ERR_W'(a_tpos_reg[a]) - ERR_W'(a_cur_reg[a]);
            frc_prev_next[a]  = ERR_W'(a_tfrc_reg[a]) - ERR_W'(clamp_force(a_frc_reg[a]));
            pos_diff_next[a]  = DIFF_W'(pos_prev_next[a]) - DIFF_W'(pos_prev_reg[a]);
            frc_diff_next[a]  = DIFF_W'(frc_prev_next[a]) - DIFF_W'(frc_prev_reg[a]);
            pos_integ_next[a] = integ_sat(pos_integ_reg[a],
                DIFF_W'(pos_prev_next[a]) + DIFF_W'(pos_prev_reg[a]));
            frc_integ_next[a] = integ_sat(frc_integ_reg[a],
                DIFF_W'(frc_prev_next[a]) + DIFF_W'(frc_prev_reg[a]));
        end
    end

    // controller state, updated once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                pos_prev_reg[a]  <= '0;
                pos_integ_reg[a] <= '0;
                frc_prev_reg[a]  <= '0;
                frc_integ_reg[a] <= '0;
            end
        end
        else if (state_upd)
        begin
            pos_prev_reg  <= pos_prev_next;
            pos_integ_reg <= pos_integ_next;
            frc_prev_reg  <= frc_prev_next;
            frc_integ_reg <= frc_integ_next;
        end
    end

    // stage b payload
    always_ff @(posedge clk)
    begin
        if (state_upd)
        begin
            b_cur_reg      <= a_cur_reg;
            b_pos_diff_reg <= pos_diff_next;
            b_frc_diff_reg <= frc_diff_next;
        end
    end

    // gain products, integrator product split in two halves
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            c_pos_kp_next[a] = PKP_W'($signed({1'b0, pos_kp_reg}))
                             * PKP_W'(pos_prev_reg[a]);
            c_pos_kd_next[a] = PKD_W'($signed({1'b0, pos_kd_reg}))
                             * PKD_W'(b_pos_diff_reg[a]);
            c_pos_lo_next[a] = PLO_W'($signed({1'b0, pos_ki_reg}))
                             * PLO_W'($signed({1'b0, pos_integ_reg[a][ILO_W-1:0]}));
            c_pos_hi_next[a] = PHI_W'($signed({1'b0, pos_ki_reg}))
                             * PHI_W'($signed(pos_integ_reg[a][INTEG_BITS-1:ILO_W]));
            c_frc_kp_next[a] = PKP_W'($signed({1'b0, frc_kp_reg}))
                             * PKP_W'(frc_prev_reg[a]);
            c_frc_kd_next[a] = PKD_W'($signed({1'b0, frc_kd_reg}))
                             * PKD_W'(b_frc_diff_reg[a]);
            c_frc_lo_next[a] = PLO_W'($signed({1'b0, frc_ki_reg}))
                             * PLO_W'($signed({1'b0, frc_integ_reg[a][ILO_W-1:0]}));
            c_frc_hi_next[a] = PHI_W'($signed({1'b0, frc_ki_reg}))
                             * PHI_W'($signed(frc_integ_reg[a][INTEG_BITS-1:ILO_W]));
        end
    end

    // stage c payload
    always_ff @(posedge clk)
    begin
        if (adv_c && b_valid_reg)
        begin
            c_cur_reg    <= b_cur_reg;
            c_pos_kp_reg <= c_pos_kp_next;
            c_pos_kd_reg <= c_pos_kd_next;
            c_pos_lo_reg <= c_pos_lo_next;
            c_pos_hi_reg <= c_pos_hi_next;
            c_frc_kp_reg <= c_frc_kp_next;
            c_frc_kd_reg <= c_frc_kd_next;
            c_frc_lo_reg <= c_frc_lo_next;
            c_frc_hi_reg <= c_frc_hi_next;
        end
    end

    // pid sums with output enables
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            d_pos_pid_next[a] = '0;
            d_frc_pid_next[a] = '0;
            if (pos_en_reg)
            begin
                d_pos_pid_next[a] = PID_W'(c_pos_kp_reg[a]) + PID_W'(c_pos_kd_reg[a])
                                  + (PID_W'(c_pos_hi_reg[a]) <<< ILO_W)
                                  + PID_W'(c_pos_lo_reg[a]);
            end
            if (frc_en_reg)
            begin
                d_frc_pid_next[a] = PID_W'(c_frc_kp_reg[a]) + PID_W'(c_frc_kd_reg[a])
                                  + (PID_W'(c_frc_hi_reg[a]) <<< ILO_W)
                                  + PID_W'(c_frc_lo_reg[a]);
            end
        end
    end

    // stage d payload
    always_ff @(posedge clk)
    begin
        if (adv_d && c_valid_reg)
        begin
            d_cur_reg     <= c_cur_reg;
            d_pos_pid_reg <= d_pos_pid_next;
            d_frc_pid_reg <= d_frc_pid_next;
        end
    end

    // commanded position: current plus position pid minus force pid
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            cmd_next[a] = shift_sat((ACC_W'(d_cur_reg[a]) <<< FRAC_W)
                                    + ACC_W'(d_pos_pid_reg[a])
                                    - ACC_W'(d_frc_pid_reg[a]));
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv_e && d_valid_reg)
        begin
            cmd_reg <= cmd_next;
        end
    end

    // checks
    `HPF_ASSERT_NEXT(a_state_hold, !state_upd,
        $stable(pos_integ_reg[0]) && $stable(frc_prev_reg[0]),
        "controller state changed without a request entering stage b")
    `HPF_ASSERT_IMPL(a_stall_full, tick_stall,
        a_valid_reg && b_valid_reg && c_valid_reg && d_valid_reg && cmd_valid_reg,
        "request stalled while the pipeline has a free stage")
    `HPF_ASSERT_IMPL(a_cmd_source, $rose(cmd_valid_reg), $past(d_valid_reg),
        "result appeared without an item in the pid sum stage")
    `HPF_ASSERT_NEXT(a_pos_disable, !pos_en_reg && adv_d && c_valid_reg,
        d_pos_pid_reg[0] == '0,
        "disabled position controller produced a nonzero output")

endmodule
